@@ design/gradient_test_pattern_pixel_core_macros.svh @@
// assertion macros for the gradient test pattern pixel core
`ifndef GRADIENT_TEST_PATTERN_PIXEL_CORE_MACROS_SVH
`define GRADIENT_TEST_PATTERN_PIXEL_CORE_MACROS_SVH

// checked only while out of reset
`define GTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/gtp_pkg.sv @@
// shared types, constants and helpers of the gradient test pattern pixel core
package gtp_pkg;

  localparam int CFG_DIM_W = 13;
  localparam int PIX_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 4;
  localparam int IDX_W     = 2;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [BYTE_W-1:0]    BYTE_FULL        = 8'hff;
  localparam logic [BYTE_W-1:0]    BYTE_ZERO        = 8'h00;
  localparam logic [BYTE_W-1:0]    ALPHA            = 8'hff;
  localparam int                   DEF_MAX_DIM      = 4096;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BYTE_ORDER   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    logic                 bgra;
  } cfg_t;

  typedef struct packed {
    logic              left;
    logic              right;
    logic              top;
    logic              bottom;
    logic [BYTE_W-1:0] blue;
  } side_t;

  function automatic int dim_width(int max_dim);
    int w;
    w = $clog2(max_dim + 1);
    return (w > CFG_DIM_W) ? CFG_DIM_W : w;
  endfunction

  function automatic logic [CFG_DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v, int max_dim);
    logic [CFG_DIM_W-1:0] res;
    res = v;
    if (int'(v) > max_dim) begin
      res = CFG_DIM_W'(max_dim);
    end
    return res;
  endfunction

endpackage

@@ design/gradient_test_pattern_pixel_core.sv @@
// top level of the gradient test pattern pixel core: register port and pixel pipeline
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-------------------------------
//   input   | in_pix_x, in_pix_y, in_frame_low       | in_valid / in_ready
//   result  | out_byte0 .. out_byte3                 | out_valid / out_ready
//   config  | psel penable pwrite paddr pwdata prdata | apb write, pready tied high
//
// one item per cycle sustained while out_ready stays high; stages are the entry stage,
// one divider stage per quotient bit of the 20-bit dividend, and the colour stage
// the restoring divider lanes for red and green set the pipeline depth
// synchronous active-low reset clears all valid bits and loads the default registers
// a stall at out_ready holds the output; stages behind it keep filling empty slots

module gradient_test_pattern_pixel_core import gtp_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pix_x,
  input  logic [PIX_W-1:0]  in_pix_y,
  input  logic [BYTE_W-1:0] in_frame_low,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte0,
  output logic [BYTE_W-1:0] out_byte1,
  output logic [BYTE_W-1:0] out_byte2,
  output logic [BYTE_W-1:0] out_byte3,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam int DIM_W = dim_width(MAX_DIM);

  logic [DIM_W-1:0] width_r, height_r;
  logic             bgra_r;
  logic             wr_en;
  reg_idx_t         idx;
  logic [CFG_DIM_W-1:0] wdata_dim;
  cfg_t             cfg;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign idx       = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
  assign wdata_dim = clamp_dim(pwdata[CFG_DIM_W-1:0], MAX_DIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(clamp_dim(FRAME_WIDTH_RST, MAX_DIM));
      height_r <= DIM_W'(clamp_dim(FRAME_HEIGHT_RST, MAX_DIM));
      bgra_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  width_r  <= DIM_W'(wdata_dim);
        REG_FRAME_HEIGHT: height_r <= DIM_W'(wdata_dim);
        REG_BYTE_ORDER:   bgra_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = APB_W'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_W'(height_r);
      REG_BYTE_ORDER:   prdata = APB_W'(bgra_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.width  = CFG_DIM_W'(width_r);
  assign cfg.height = CFG_DIM_W'(height_r);
  assign cfg.bgra   = bgra_r;

  gtp_grad_pipe #(.MAX_DIM(MAX_DIM)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pix_x     (in_pix_x),
    .pix_y     (in_pix_y),
    .frame_low (in_frame_low),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte0     (out_byte0),
    .byte1     (out_byte1),
    .byte2     (out_byte2),
    .byte3     (out_byte3)
  );

endmodule

@@ design/gtp_div_step.sv @@
// one restoring division step: one quotient bit per call
module gtp_div_step import gtp_pkg::*; #(
  parameter int DIM_W = 13,
  parameter int ACC_W = 20
) (
  input  logic [DIM_W-1:0] div,
  input  logic [DIM_W-1:0] rem_in,
  input  logic [ACC_W-1:0] acc_in,
  output logic [DIM_W-1:0] rem_out,
  output logic [ACC_W-1:0] acc_out
);

  logic [DIM_W:0] trial;
  logic [DIM_W:0] diff;
  logic           ge;

  assign trial   = {rem_in, acc_in[ACC_W-1]};
  assign diff    = trial - {1'b0, div};
  assign ge      = (trial >= {1'b0, div});
  assign rem_out = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  assign acc_out = {acc_in[ACC_W-2:0], ge};

endmodule

@@ design/gtp_grad_pipe.sv @@
// pixel pipeline: entry stage, pipelined dividers for red and green, colour output stage
module gtp_grad_pipe import gtp_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pix_x,
  input  logic [PIX_W-1:0]  pix_y,
  input  logic [BYTE_W-1:0] frame_low,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] byte0,
  output logic [BYTE_W-1:0] byte1,
  output logic [BYTE_W-1:0] byte2,
  output logic [BYTE_W-1:0] byte3
);

  localparam int DIM_W = dim_width(MAX_DIM);
  localparam int ACC_W = PIX_W + BYTE_W;
  localparam int NSTG  = ACC_W;

  logic             v_r    [NSTG+1];
  logic [DIM_W-1:0] rrem_r [NSTG+1];
  logic [ACC_W-1:0] racc_r [NSTG+1];
  logic [DIM_W-1:0] grem_r [NSTG+1];
  logic [ACC_W-1:0] gacc_r [NSTG+1];
  side_t            side_r [NSTG+1];
  logic             en     [NSTG+1];

  logic [DIM_W-1:0] rrem_nxt [NSTG+1];
  logic [ACC_W-1:0] racc_nxt [NSTG+1];
  logic [DIM_W-1:0] grem_nxt [NSTG+1];
  logic [ACC_W-1:0] gacc_nxt [NSTG+1];

  logic              out_v_r;
  logic [BYTE_W-1:0] b0_r, b1_r, b2_r;
  logic              en_out;

  logic [DIM_W-1:0]     wdiv, hdiv;
  logic [CFG_DIM_W-1:0] wq, hq, wlim, hlim, x_ext, y_ext;
  side_t                side_in;
  logic [BYTE_W-1:0]    red, green, blue;
  logic                 w_flat, h_flat;
  side_t                sd;

  assign wdiv = cfg.width[DIM_W-1:0] - DIM_W'(1);
  assign hdiv = cfg.height[DIM_W-1:0] - DIM_W'(1);

  // stall chain: a stage moves when it is empty or its successor moves
  assign en_out    = !out_v_r || out_ready;
  assign en[NSTG]  = !v_r[NSTG] || en_out;
  assign in_ready  = en[0];

  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  // corner regions and blue at entry
  always_comb begin
    wq    = cfg.width >> 2;
    hq    = cfg.height >> 2;
    wlim  = cfg.width - wq;
    hlim  = cfg.height - hq;
    x_ext = CFG_DIM_W'(pix_x);
    y_ext = CFG_DIM_W'(pix_y);
    side_in.left   = x_ext < wq;
    side_in.right  = wlim <= x_ext;
    side_in.top    = y_ext < hq;
    side_in.bottom = hlim <= y_ext;
    side_in.blue   = (frame_low << 3) - frame_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rrem_r[0] <= '0;
      grem_r[0] <= '0;
      racc_r[0] <= {pix_x, BYTE_ZERO} - ACC_W'(pix_x);
      gacc_r[0] <= {pix_y, BYTE_ZERO} - ACC_W'(pix_y);
      side_r[0] <= side_in;
    end
  end

  assign rrem_nxt[0] = '0;
  assign racc_nxt[0] = '0;
  assign grem_nxt[0] = '0;
  assign gacc_nxt[0] = '0;

  for (genvar i = 1; i <= NSTG; i++) begin : g_stage
    gtp_div_step #(.DIM_W(DIM_W), .ACC_W(ACC_W)) u_red (
      .div     (wdiv),
      .rem_in  (rrem_r[i-1]),
      .acc_in  (racc_r[i-1]),
      .rem_out (rrem_nxt[i]),
      .acc_out (racc_nxt[i])
    );

    gtp_div_step #(.DIM_W(DIM_W), .ACC_W(ACC_W)) u_green (
      .div     (hdiv),
      .rem_in  (grem_r[i-1]),
      .acc_in  (gacc_r[i-1]),
      .rem_out (grem_nxt[i]),
      .acc_out (gacc_nxt[i])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rrem_r[i] <= rrem_nxt[i];
        racc_r[i] <= racc_nxt[i];
        grem_r[i] <= grem_nxt[i];
        gacc_r[i] <= gacc_nxt[i];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // colour select and byte order
  always_comb begin
    sd     = side_r[NSTG];
    w_flat = cfg.width <= CFG_DIM_W'(1);
    h_flat = cfg.height <= CFG_DIM_W'(1);
    red    = w_flat ? BYTE_ZERO : racc_r[NSTG][BYTE_W-1:0];
    green  = h_flat ? BYTE_ZERO : gacc_r[NSTG][BYTE_W-1:0];
    blue   = sd.blue;
    if (sd.left && sd.top) begin
      red = BYTE_FULL; green = BYTE_ZERO; blue = BYTE_ZERO;
    end else if (sd.right && sd.top) begin
      red = BYTE_ZERO; green = BYTE_FULL; blue = BYTE_ZERO;
    end else if (sd.left && sd.bottom) begin
      red = BYTE_ZERO; green = BYTE_ZERO; blue = BYTE_FULL;
    end else if (sd.right && sd.bottom) begin
      red = BYTE_FULL; green = BYTE_FULL; blue = BYTE_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      b0_r <= cfg.bgra ? blue : red;
      b1_r <= green;
      b2_r <= cfg.bgra ? red : blue;
    end
  end

  assign out_valid = out_v_r;
  assign byte0     = b0_r;
  assign byte1     = b1_r;
  assign byte2     = b2_r;
  assign byte3     = ALPHA;

endmodule

@@ design/gtp_checker.sv @@
// port-level assertion checker for the gradient test pattern pixel core, with its bind
`include "gradient_test_pattern_pixel_core_macros.svh"

module gtp_checker import gtp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte0,
  input logic [BYTE_W-1:0] out_byte1,
  input logic [BYTE_W-1:0] out_byte2,
  input logic [BYTE_W-1:0] out_byte3
);

  `GTP_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `GTP_ASSERT(a_alpha_full, out_valid |-> out_byte3 == ALPHA, "alpha byte not full")

  `GTP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `GTP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_byte0, out_byte1, out_byte2}), "result changed")

endmodule

bind gradient_test_pattern_pixel_core gtp_checker u_gtp_checker (.*);
